>>> rtl/core/bds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bolus delivery scheduler package
// Shared widths, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package bds_pkg;
  localparam int HistoryDepth = 8;
  localparam int HistBits = 3;
  localparam int PulseBits = 16;
  localparam int MinBits = 11;
  localparam int RatioLimit = 100;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  localparam logic [1:0] TYPE_FAST = 2'd0;
  localparam logic [1:0] TYPE_EXT = 2'd1;
  localparam logic [1:0] TYPE_DUAL = 2'd2;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_IMM = 2'd1;
  localparam logic [1:0] PH_EXT = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic div_hi;
    logic start_commit;
    logic stop_commit;
    logic poll_commit;
    logic set_out;
  } bds_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic id_hit;
    logic div_done;
  } bds_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/bds_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bolus delivery scheduler controller
// Sequences history scan, slot divisions and the commit of each word.
// ----------------------------------------------------------------------------
module bds_ctrl import bds_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire logic [1:0] operation,
  output bds_cmd_t      cmd,
  input  wire bds_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DIVB = 3'd3,
                         S_COMMIT = 3'd4, S_OUT = 3'd5, S_DIV0 = 3'd6;
  logic [2:0] state, state_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_START;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && !in_stall) op <= operation;
      if (cmd.set_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (op == OP_START) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_done || sts.id_hit) state_next = S_COMMIT;
        end else if (op == OP_POLL) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_done) state_next = S_DIV0;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVB;
      end
      S_DIVB: begin
        cmd.div_step = 1'b1;
        cmd.div_hi = 1'b1;
        if (sts.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.start_commit = (op == OP_START);
        cmd.stop_commit = (op == OP_STOP);
        cmd.poll_commit = (op == OP_POLL);
        cmd.set_out = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/bds_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bolus delivery scheduler datapath
// Delivery state, id history, serial dividers and the result register.
// ----------------------------------------------------------------------------
module bds_datapath import bds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_data,
  input  wire bds_cmd_t    cmd,
  output bds_sts_t         sts,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] op_id,
  input  wire logic [1:0]  bolus_type,
  input  wire logic        dose_nonzero,
  input  wire logic [7:0]  dual_ratio,
  input  wire logic [15:0] first_part_pulses,
  input  wire logic [15:0] second_part_pulses,
  input  wire logic [10:0] extension_minutes,
  input  wire logic [2:0]  stop_reason,
  output logic             accepted,
  output logic [15:0]      pulse_count,
  output logic             final_flag,
  output logic             event_valid,
  output logic [2:0]       event_reason,
  output logic             busy_res
);
  logic [5:0] period;
  logic running;
  logic [1:0] phase, delivery_type;
  logic [15:0] saved_second, phase_total, pulses_sent;
  logic [10:0] saved_min, slot_index, slot_count;
  logic [31:0] hist [HistoryDepth];
  logic [HistBits-1:0] hist_ptr;
  logic [3:0] hist_fill;

  logic [1:0] r_type;
  logic r_nz;
  logic [7:0] r_ratio;
  logic [15:0] r_first, r_second;
  logic [10:0] r_min;
  logic [2:0] r_reason;
  logic [31:0] r_id;
  logic [3:0] scan_i;
  logic hit;

  // Poll targets resolved at division start: total and slot count for the slot share.
  logic [15:0] d_total;
  logic [10:0] d_slots, d_idx;
  logic [10:0] slots_calc;
  logic [5:0] per_eff;
  logic [11:0] num;
  logic [27:0] dividend;
  logic [11:0] rem;
  logic [26:0] quo;
  logic [4:0] dcnt;
  logic dbusy;
  // Slot count division of minutes by the period, run alongside the scan.
  logic [11:0] srem;
  logic [10:0] squo;
  logic [3:0] scnt;

  assign per_eff = (period == 6'd0) ? 6'd1 : period;
  assign sts.scan_done = (scan_i >= hist_fill) && (scnt == 4'd0);
  assign sts.id_hit = 1'b0;
  assign sts.div_done = dbusy && (dcnt == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) period <= 6'd3;
    else if (cfg_we) period <= cfg_data;
  end

  // Effective phase for a poll: an empty dual immediate part jumps to extended.
  logic imm_jump;
  assign imm_jump = (phase == PH_IMM) && (phase_total == pulses_sent) &&
                    (delivery_type == TYPE_DUAL);

  logic [10:0] slot_div_q;
  assign slot_div_q = squo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type <= bolus_type; r_nz <= dose_nonzero; r_ratio <= dual_ratio;
      r_first <= first_part_pulses; r_second <= second_part_pulses;
      r_min <= extension_minutes; r_reason <= stop_reason; r_id <= op_id;
      scan_i <= 4'd0; hit <= 1'b0;
      num <= {1'b0, (operation == OP_START) ? extension_minutes : saved_min} +
             {6'd0, per_eff} - 12'd1;
      srem <= 12'd0; squo <= 11'd0; scnt <= 4'd12;
      dbusy <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (scan_i < hist_fill) begin
        if (hist[scan_i[HistBits-1:0]] == r_id) hit <= 1'b1;
        scan_i <= scan_i + 4'd1;
      end
      if (scnt != 4'd0) begin
        if ({srem[10:0], num[11]} >= {6'd0, per_eff}) begin
          srem <= {srem[10:0], num[11]} - {6'd0, per_eff};
          squo <= {squo[9:0], 1'b1};
        end else begin
          srem <= {srem[10:0], num[11]};
          squo <= {squo[9:0], 1'b0};
        end
        num <= {num[10:0], 1'b0};
        scnt <= scnt - 4'd1;
      end
    end
    if (cmd.div_start) begin
      d_total <= imm_jump ? saved_second : phase_total;
      d_slots <= imm_jump ? slots_calc : slot_count;
      d_idx <= imm_jump ? 11'd0 : slot_index;
    end
    if (cmd.div_step) begin
      if (!dbusy) begin
        dividend <= d_total * (cmd.div_hi ? ({17'd0, d_idx} + 28'd1) : {17'd0, d_idx});
        rem <= 12'd0; quo <= 27'd0; dcnt <= 5'd28; dbusy <= 1'b1;
      end else if (dcnt != 5'd0) begin
        if ({rem[10:0], dividend[27]} >= {1'b0, d_slots}) begin
          rem <= {rem[10:0], dividend[27]} - {1'b0, d_slots};
          quo <= {quo[25:0], 1'b1};
        end else begin
          rem <= {rem[10:0], dividend[27]};
          quo <= {quo[25:0], 1'b0};
        end
        dividend <= {dividend[26:0], 1'b0};
        dcnt <= dcnt - 5'd1;
      end else begin
        dbusy <= 1'b0;
      end
    end
  end

  // The scan of a poll divides the saved minutes, which gives the slot count
  // of the extended part of a dual delivery.
  assign slots_calc = (saved_min == 11'd0) ? 11'd1 : squo;

  // Pulses already sent equal the lower bound of the current slot.
  logic [15:0] share;
  assign share = 16'(quo) - (imm_jump ? 16'd0 : pulses_sent);

  logic start_ok;
  assign start_ok = !running && r_nz && (r_type <= TYPE_DUAL) &&
                    !(r_type == TYPE_DUAL && r_ratio > 8'(RatioLimit)) && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0; phase <= PH_NONE; delivery_type <= TYPE_FAST;
      saved_second <= '0; saved_min <= '0; phase_total <= '0; pulses_sent <= '0;
      slot_index <= '0; slot_count <= '0; hist_ptr <= '0; hist_fill <= '0;
      for (int i = 0; i < HistoryDepth; i++) hist[i] <= 32'd0;
    end else if (cmd.start_commit) begin
      accepted <= start_ok; pulse_count <= '0; final_flag <= 1'b0;
      event_valid <= 1'b0; event_reason <= 3'd0;
      if (start_ok) begin
        hist[hist_ptr] <= r_id;
        hist_ptr <= hist_ptr + 1'b1;
        if (hist_fill < 4'(HistoryDepth)) hist_fill <= hist_fill + 4'd1;
        delivery_type <= r_type; saved_second <= r_second; saved_min <= r_min;
        pulses_sent <= '0; running <= 1'b1;
        if (r_type == TYPE_EXT) begin
          phase <= PH_EXT; phase_total <= r_second; slot_index <= '0;
          slot_count <= (r_min == 11'd0) ? 11'd1 : slot_div_q;
        end else begin
          phase <= PH_IMM; phase_total <= r_first;
        end
      end
      busy_res <= running | start_ok;
    end else if (cmd.stop_commit) begin
      accepted <= 1'b0; pulse_count <= '0; final_flag <= 1'b0;
      event_valid <= running; event_reason <= running ? r_reason : 3'd0;
      running <= 1'b0; busy_res <= 1'b0;
      if (running) phase <= PH_NONE;
    end else if (cmd.poll_commit) begin
      accepted <= running; pulse_count <= '0; final_flag <= 1'b0;
      event_valid <= 1'b0; event_reason <= 3'd0; busy_res <= running;
      if (running) begin
        if (phase == PH_IMM && phase_total != pulses_sent) begin
          pulse_count <= phase_total - pulses_sent;
          pulses_sent <= phase_total; final_flag <= 1'b1;
          if (delivery_type != TYPE_DUAL) begin
            running <= 1'b0; phase <= PH_NONE; event_valid <= 1'b1; busy_res <= 1'b0;
          end
        end else if (phase == PH_IMM && !imm_jump) begin
          running <= 1'b0; phase <= PH_NONE; final_flag <= 1'b1;
          event_valid <= 1'b1; busy_res <= 1'b0;
        end else if (phase == PH_EXT || imm_jump) begin
          if (imm_jump) begin
            phase <= PH_EXT; phase_total <= saved_second; slot_count <= slots_calc;
          end
          if (d_idx >= d_slots) begin
            running <= 1'b0; phase <= PH_NONE; final_flag <= 1'b1;
            event_valid <= 1'b1; busy_res <= 1'b0;
          end else begin
            pulse_count <= share;
            slot_index <= d_idx + 11'd1;
            pulses_sent <= (imm_jump ? 16'd0 : pulses_sent) + share;
          end
        end
      end
    end else if (cmd.set_out) begin
      accepted <= 1'b0; pulse_count <= '0; final_flag <= 1'b0;
      event_valid <= 1'b0; event_reason <= 3'd0; busy_res <= running;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/bolus_delivery_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bolus delivery scheduler
// Schedules fast, extended and dual dose pulses from start, stop and poll words.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// in        input      in_valid / in_stall
// out       output     out_valid / out_stall
// cfg       input      cfg_we / cfg_data
// A start runs the history scan and slot-count division, a stop or an unknown
// word goes straight to commit, and a poll adds one 28-step serial division.
// Reset is synchronous and clears all delivery state and the id history.
// The input is stalled in reset, while a word is in work or a result waits unread.
// ----------------------------------------------------------------------------
module bolus_delivery_scheduler import bds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] op_id,
  input  wire logic [1:0]  bolus_type,
  input  wire logic        dose_nonzero,
  input  wire logic [7:0]  dual_ratio,
  input  wire logic [15:0] first_part_pulses,
  input  wire logic [15:0] second_part_pulses,
  input  wire logic [10:0] extension_minutes,
  input  wire logic [2:0]  stop_reason,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic [15:0]      pulse_count,
  output logic             final_flag,
  output logic             event_valid,
  output logic [2:0]       event_reason,
  output logic             busy_res
);
  bds_cmd_t cmd;
  bds_sts_t sts;

  bds_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .operation,
    .cmd, .sts
  );

  bds_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .cmd, .sts, .operation, .op_id, .bolus_type,
    .dose_nonzero, .dual_ratio, .first_part_pulses, .second_part_pulses,
    .extension_minutes, .stop_reason, .accepted, .pulse_count, .final_flag,
    .event_valid, .event_reason, .busy_res
  );
endmodule
`default_nettype wire

>>> tb/sv/bolus_delivery_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bolus delivery scheduler checker
// Watches the input, output and configuration ports, predicts the result of
// every accepted word from its own model of the scheduler and compares each
// result field by field in order.
// ----------------------------------------------------------------------------
module bolus_delivery_scheduler_checker import bds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] op_id,
  input  wire logic [1:0]  bolus_type,
  input  wire logic        dose_nonzero,
  input  wire logic [7:0]  dual_ratio,
  input  wire logic [15:0] first_part_pulses,
  input  wire logic [15:0] second_part_pulses,
  input  wire logic [10:0] extension_minutes,
  input  wire logic [2:0]  stop_reason,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        accepted,
  input  wire logic [15:0] pulse_count,
  input  wire logic        final_flag,
  input  wire logic        event_valid,
  input  wire logic [2:0]  event_reason,
  input  wire logic        busy_res,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  typedef struct packed {
    logic        acc;
    logic [15:0] pulses;
    logic        fin;
    logic        ev;
    logic [2:0]  reason;
    logic        busy;
  } sched_result_t;

  sched_result_t expected_q[$];

  logic [5:0]  period;
  logic        running;
  logic [1:0]  phase;
  logic [1:0]  dtype;
  logic [15:0] saved_second;
  logic [10:0] saved_minutes;
  logic [15:0] phase_total;
  logic [15:0] sent;
  logic [10:0] slot_idx;
  logic [10:0] slot_cnt;
  logic [31:0] ids [HistoryDepth];
  int          id_ptr;
  int          id_fill;

  function automatic logic [10:0] slot_total(logic [10:0] minutes);
    int per;
    per = (period == 0) ? 1 : period;
    if (minutes == 0) return 11'd1;
    return 11'((int'(minutes) + per - 1) / per);
  endfunction

  function automatic logic [15:0] slot_pulses(logic [15:0] total, logic [10:0] idx,
                                              logic [10:0] slots);
    longint hi;
    longint lo;
    longint i;
    if (slots == 0) return total;
    i = (idx >= slots) ? slots - 1 : idx;
    hi = (i + 1) * longint'(total) / slots;
    lo = i * longint'(total) / slots;
    return 16'(hi - lo);
  endfunction

  task automatic begin_extended(logic [15:0] total, logic [10:0] minutes);
    phase = PH_EXT;
    phase_total = total;
    slot_cnt = slot_total(minutes);
    slot_idx = '0;
    sent = '0;
  endtask

  task automatic predict_schedule(output sched_result_t r);
    logic ok;
    logic known;
    logic [15:0] remain;
    logic [15:0] p;
    r = '0;
    if (operation == OP_START) begin
      known = 1'b0;
      for (int i = 0; i < id_fill; i++) begin
        if (ids[i] == op_id) known = 1'b1;
      end
      ok = !running && dose_nonzero && bolus_type <= TYPE_DUAL &&
           !(bolus_type == TYPE_DUAL && dual_ratio > RatioLimit) && !known;
      if (ok) begin
        ids[id_ptr] = op_id;
        id_ptr = (id_ptr + 1) % HistoryDepth;
        if (id_fill < HistoryDepth) id_fill++;
        dtype = bolus_type;
        saved_second = second_part_pulses;
        saved_minutes = extension_minutes;
        if (bolus_type == TYPE_EXT) begin
          begin_extended(second_part_pulses, extension_minutes);
        end else begin
          phase = PH_IMM;
          phase_total = first_part_pulses;
          sent = '0;
        end
        running = 1'b1;
        r.acc = 1'b1;
      end
    end else if (operation == OP_STOP) begin
      if (running) begin
        running = 1'b0;
        phase = PH_NONE;
        r.ev = 1'b1;
        r.reason = stop_reason;
      end
    end else if (operation == OP_POLL && running) begin
      r.acc = 1'b1;
      if (phase == PH_IMM) begin
        remain = phase_total - sent;
        if (remain != 0) begin
          r.pulses = remain;
          sent = phase_total;
          r.fin = 1'b1;
          if (dtype != TYPE_DUAL) begin
            running = 1'b0;
            phase = PH_NONE;
            r.ev = 1'b1;
          end
        end else if (dtype == TYPE_DUAL) begin
          begin_extended(saved_second, saved_minutes);
        end else begin
          running = 1'b0;
          phase = PH_NONE;
          r.fin = 1'b1;
          r.ev = 1'b1;
        end
      end
      if (running && phase == PH_EXT && !r.fin) begin
        if (slot_idx >= slot_cnt) begin
          running = 1'b0;
          phase = PH_NONE;
          r.fin = 1'b1;
          r.ev = 1'b1;
        end else begin
          p = slot_pulses(phase_total, slot_idx, slot_cnt);
          slot_idx = slot_idx + 1'b1;
          sent = sent + p;
          r.pulses = p;
        end
      end
    end
    r.busy = running;
  endtask

  always @(posedge clk) begin
    sched_result_t r;
    sched_result_t e;
    if (rst) begin
      period <= 6'd3;
      running = 1'b0;
      phase = PH_NONE;
      dtype = TYPE_FAST;
      saved_second = '0;
      saved_minutes = '0;
      phase_total = '0;
      sent = '0;
      slot_idx = '0;
      slot_cnt = '0;
      for (int i = 0; i < HistoryDepth; i++) ids[i] = '0;
      id_ptr = 0;
      id_fill = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) period <= cfg_data;
      if (in_valid && !in_stall) begin
        predict_schedule(r);
        expected_q.push_back(r);
      end
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $error("result with no word outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.acc !== accepted || e.pulses !== pulse_count || e.fin !== final_flag ||
              e.ev !== event_valid || e.reason !== event_reason || e.busy !== busy_res)
            fail_count <= fail_count + 1;
          if (e.acc !== accepted)
            $error("accepted: expected %0d, got %0d", e.acc, accepted);
          if (e.pulses !== pulse_count)
            $error("pulse_count: expected %0d, got %0d", e.pulses, pulse_count);
          if (e.fin !== final_flag)
            $error("final_flag: expected %0d, got %0d", e.fin, final_flag);
          if (e.ev !== event_valid)
            $error("event_valid: expected %0d, got %0d", e.ev, event_valid);
          if (e.reason !== event_reason)
            $error("event_reason: expected %0d, got %0d", e.reason, event_reason);
          if (e.busy !== busy_res)
            $error("busy_res: expected %0d, got %0d", e.busy, busy_res);
        end
      end
    end
  end

  assign pending_count = expected_q.size();
endmodule

>>> tb/sv/bolus_delivery_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bolus delivery scheduler test
// Drives directed and random start, stop and poll words through the
// scheduler under random idling and a long output hold-off, changes the slot
// period between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module bolus_delivery_scheduler_test import bds_pkg::*;;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [31:0] op_id;
  logic [1:0]  bolus_type;
  logic        dose_nonzero;
  logic [7:0]  dual_ratio;
  logic [15:0] first_part_pulses;
  logic [15:0] second_part_pulses;
  logic [10:0] extension_minutes;
  logic [2:0]  stop_reason;
  logic        out_valid;
  logic        out_stall;
  logic        accepted;
  logic [15:0] pulse_count;
  logic        final_flag;
  logic        event_valid;
  logic [2:0]  event_reason;
  logic        busy_res;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          words_sent;
  bit          quiet;
  bit          hold_off;
  logic [31:0] next_id;

  bolus_delivery_scheduler i_dut (.*);

  bolus_delivery_scheduler_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("bolus_delivery_scheduler test failed");
    $finish;
  end

  // Receiver: random stall bursts, none once quiet is set.
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(15, 1)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [31:0] id, logic [1:0] kind, logic nz,
                           logic [7:0] ratio, logic [15:0] first, logic [15:0] second,
                           logic [10:0] minutes, logic [2:0] reason);
    if (!quiet && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    op_id <= id;
    bolus_type <= kind;
    dose_nonzero <= nz;
    dual_ratio <= ratio;
    first_part_pulses <= first;
    second_part_pulses <= second;
    extension_minutes <= minutes;
    stop_reason <= reason;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_start(logic [1:0] kind, logic [15:0] first, logic [15:0] second,
                            logic [10:0] minutes, logic [7:0] ratio);
    next_id = next_id + 32'd1;
    send_word(OP_START, next_id, kind, 1'b1, ratio, first, second, minutes, 3'd0);
  endtask

  task automatic send_poll();
    send_word(OP_POLL, $urandom, 2'($urandom), 1'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 11'($urandom), 3'($urandom));
  endtask

  task automatic send_stop(logic [2:0] reason);
    send_word(OP_STOP, $urandom, 2'($urandom), 1'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 11'($urandom), reason);
  endtask

  task automatic drain_and_set_period(logic [5:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_delivery();
    logic [1:0] kind;
    int polls;
    kind = 2'($urandom_range(2));
    if ($urandom_range(9) == 0) begin
      send_start(kind, 16'($urandom), 16'($urandom), 11'($urandom_range(1440)),
                 8'($urandom_range(255)));
    end else begin
      send_start(kind, 16'($urandom_range(40)), 16'($urandom_range(200)),
                 11'($urandom_range(60)), 8'($urandom_range(100)));
    end
    polls = $urandom_range(25, 1);
    for (int i = 0; i < polls; i++) begin
      if ($urandom_range(15) == 0) send_stop(3'($urandom));
      else if ($urandom_range(20) == 0) begin
        send_word(2'($urandom), $urandom, 2'($urandom), 1'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom), 11'($urandom), 3'($urandom));
      end else send_poll();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_POLL;
    op_id = '0;
    bolus_type = TYPE_FAST;
    dose_nonzero = 1'b0;
    dual_ratio = '0;
    first_part_pulses = '0;
    second_part_pulses = '0;
    extension_minutes = '0;
    stop_reason = '0;
    quiet = 1'b0;
    hold_off = 1'b0;
    words_sent = 0;
    next_id = 32'd100;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle stop and poll, op id zero, refusals and each type.
    send_stop(3'd5);
    send_poll();
    send_word(2'd3, 32'hFFFF_FFFF, 2'd3, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 11'h7FF, 3'd7);
    send_word(OP_START, 32'd0, TYPE_FAST, 1'b1, 8'd0, 16'hFFFF, 16'd0, 11'd0, 3'd0);
    send_word(OP_START, 32'd1, TYPE_EXT, 1'b1, 8'd0, 16'd1, 16'd1, 11'd1, 3'd0);
    send_poll();
    send_word(OP_START, 32'd0, TYPE_FAST, 1'b1, 8'd0, 16'd5, 16'd0, 11'd0, 3'd0);
    send_word(OP_START, 32'd2, TYPE_FAST, 1'b0, 8'd0, 16'd5, 16'd0, 11'd0, 3'd0);
    send_word(OP_START, 32'd3, TYPE_DUAL, 1'b1, 8'd101, 16'd5, 16'd5, 11'd5, 3'd0);
    send_word(OP_START, 32'd4, 2'd3, 1'b1, 8'd0, 16'd5, 16'd5, 11'd5, 3'd0);
    send_word(OP_START, 32'd5, TYPE_DUAL, 1'b1, 8'd100, 16'd0, 16'd2, 11'd1440, 3'd0);
    send_poll();
    send_stop(3'd0);
    send_start(TYPE_EXT, 16'd2, 16'd2, 11'd9, 8'd0);
    repeat (4) send_poll();
    send_start(TYPE_FAST, 16'd0, 16'd0, 11'd0, 8'd0);
    send_poll();
    send_start(TYPE_DUAL, 16'd7, 16'hFFFF, 11'd3, 8'd60);
    repeat (3) send_poll();
    send_stop(3'd7);

    // Long receiver hold-off while words keep coming.
    hold_off = 1'b1;
    random_delivery();

    drain_and_set_period(6'd0);
    repeat (12) random_delivery();
    drain_and_set_period(6'd63);
    send_start(TYPE_EXT, 16'd0, 16'hFFFF, 11'd1440, 8'd0);
    repeat (25) send_poll();
    repeat (10) random_delivery();
    drain_and_set_period(6'd1);
    send_start(TYPE_EXT, 16'd0, 16'd3, 11'd8, 8'd0);
    repeat (10) send_poll();
    while (words_sent < 650) random_delivery();
    drain_and_set_period(6'd60);
    quiet = 1'b1;
    while (words_sent < 850) random_delivery();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d words over slot periods 3, 0, 63, 1 and 60; checked %0d results.",
             words_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("bolus_delivery_scheduler test passed");
    end else begin
      $display("bolus_delivery_scheduler test failed");
    end
    $finish;
  end
endmodule
